// ===== rtl/core/pilc_pkg.sv =====
// Package for the pack index parser and lookup core.
// Holds types, constants and the parser phase enum; no dependencies.
package pilc_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned TableAw = $clog2(TableEntries);
  localparam int unsigned CountW = 11;

  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001B3;
  localparam logic [31:0] PackMagic = 32'h554D504B;
  localparam logic [15:0] PackEndian = 16'h1234;
  localparam logic [31:0] HeaderBytes = 32'd16;

  localparam logic [1:0] StBusy = 2'd0;
  localparam logic [1:0] StDone = 2'd1;
  localparam logic [1:0] StBad = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  localparam logic [1:0] RegPackLength = 2'd0;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_ENDIAN, PH_FLAGS, PH_COUNT, PH_NAMELEN,
    PH_NAME, PH_OFFSET, PH_CLEN, PH_OLEN, PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {LK_IDLE, LK_READ, LK_DONE} lk_state_t;

  // Table entry as stored in memory.
  typedef struct packed {
    logic [63:0] id;
    logic [31:0] offset;
    logic [31:0] length;
  } entry_t;

  // Field length in bytes for each fixed-size phase.
  function automatic logic [3:0] field_len(input phase_t ph);
    logic [3:0] n;
    unique case (ph)
      PH_VERSION, PH_ENDIAN: n = 4'd2;
      PH_OFFSET: n = 4'd8;
      PH_NAME, PH_IDLE: n = 4'd0;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/pilc_if.sv =====
// Valid/ready channel interface for the core's input and output transactions.
// Does not depend on pilc_pkg; its widths are written here.
interface pilc_in_if;
  logic valid;
  logic ready;
  logic op;
  logic first_byte;
  logic [7:0] pack_byte;
  logic [63:0] lookup_id;
  modport source(output valid, op, first_byte, pack_byte, lookup_id, input ready);
  modport sink(input valid, op, first_byte, pack_byte, lookup_id, output ready);
endinterface

interface pilc_out_if;
  logic valid;
  logic ready;
  logic [1:0] parse_status;
  logic [10:0] entries_stored;
  logic found;
  logic [31:0] asset_offset;
  logic [31:0] asset_length;
  modport source(output valid, parse_status, entries_stored, found, asset_offset,
                 asset_length, input ready);
  modport sink(input valid, parse_status, entries_stored, found, asset_offset,
               asset_length, output ready);
endinterface

// ===== rtl/core/pilc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pilc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/pilc_parser.sv =====
// Byte parser: header, entry fields, FNV-1a hashing and table writes.
// Depends on pilc_pkg.
module pilc_parser
  import pilc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              first_byte,
  input  logic [7:0]        pack_byte,
  input  logic [31:0]       pack_length,
  output logic [1:0]        status,
  output logic [CountW-1:0] stored_count,
  output logic              we,
  output logic [TableAw-1:0] waddr,
  output entry_t            wdata
);
  phase_t      phase, ph;
  logic [31:0] byte_position, name_left, entries_left;
  logic [63:0] acc, hash, f0, f1, f2;
  logic [2:0]  fcount;

  // Working copies after an optional clear.
  logic [31:0] bp, nl, el;
  logic [63:0] ac, hs, e0, e1, e2, v;
  logic [2:0]  fc;
  logic [1:0]  st;
  logic [CountW-1:0] ec;
  logic [31:0] pos;
  logic [63:0] hx, prod;
  logic        done_field, bad, fin;
  logic [33:0] sum4;
  logic [65:0] sumn;
  logic [64:0] offlen;

  logic [31:0] bp_next, nl_next, el_next;
  logic [63:0] ac_next, hs_next, e0_next, e1_next, e2_next;
  logic [2:0]  fc_next;
  logic [1:0]  st_next;
  logic [CountW-1:0] ec_next;
  phase_t      ph_next;

  // The FNV prime is 2^40 + 0x1B3, so the product is a sum of shifted copies.
  assign hx = hs ^ {56'd0, pack_byte};
  assign prod = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4) + (hx << 1) + hx;

  always_comb begin
    ph = phase; bp = byte_position; nl = name_left; el = entries_left;
    ac = acc; hs = hash; e0 = f0; e1 = f1; e2 = f2; fc = fcount;
    st = status; ec = stored_count;
    if (first_byte) begin
      ph = PH_MAGIC; bp = '0; nl = '0; el = '0; ac = '0; hs = FnvBasis;
      e0 = '0; e1 = '0; e2 = '0; fc = '0; st = StBusy; ec = '0;
    end
    ph_next = ph; bp_next = bp; nl_next = nl; el_next = el; ac_next = ac;
    hs_next = hs; e0_next = e0; e1_next = e1; e2_next = e2; fc_next = fc;
    st_next = st; ec_next = ec;
    we = 1'b0;
    waddr = ec[TableAw-1:0];
    wdata = '{id: hs, offset: e0[31:0], length: e2[31:0]};
    pos = bp + 32'd1;
    v = ac | ({56'd0, pack_byte} << {fc, 3'b000});
    done_field = ({1'b0, fc} + 4'd1) >= field_len(ph);
    bad = 1'b0;
    fin = 1'b0;
    sum4 = {2'b0, pos} + 34'd4;
    sumn = {34'd0, pos} + {2'd0, v} + 66'd16;
    offlen = {1'b0, e0} + {33'd0, v[31:0]};
    if (st == StBusy && ph != PH_IDLE) begin
      if (ph == PH_MAGIC && bp == '0 && fc == '0 && pack_length < HeaderBytes) begin
        bad = 1'b1;
      end else if (ph == PH_NAME) begin
        bp_next = pos;
        hs_next = prod;
        nl_next = nl - 32'd1;
        if (nl == 32'd1) ph_next = PH_OFFSET;
      end else begin
        bp_next = pos;
        ac_next = v;
        fc_next = fc + 3'd1;
        if (done_field) begin
          fc_next = '0;
          ac_next = '0;
          unique case (ph)
            PH_MAGIC: begin e0_next = v; ph_next = PH_VERSION; end
            PH_VERSION: ph_next = PH_ENDIAN;
            PH_ENDIAN: begin e1_next = v; ph_next = PH_FLAGS; end
            PH_FLAGS: ph_next = PH_COUNT;
            PH_COUNT: begin
              if (e0 != {32'd0, PackMagic} || e1 != {48'd0, PackEndian}) bad = 1'b1;
              else begin el_next = v[31:0]; fin = 1'b1; end
            end
            PH_NAMELEN: begin
              if (sumn > {34'd0, pack_length}) bad = 1'b1;
              else begin
                nl_next = v[31:0];
                hs_next = FnvBasis;
                ph_next = (v[31:0] == '0) ? PH_OFFSET : PH_NAME;
              end
            end
            PH_OFFSET: begin e0_next = v; ph_next = PH_CLEN; end
            PH_CLEN: begin e1_next = v; ph_next = PH_OLEN; end
            PH_OLEN: begin
              e2_next = v;
              if (ec >= CountW'(TableEntries)) begin
                st_next = StFull; ph_next = PH_IDLE;
              end else if (e1 == v) begin
                if (e0 > {32'd0, pack_length} || offlen > {33'd0, pack_length}
                    || v[63:32] != '0) begin
                  bad = 1'b1;
                end else begin
                  we = 1'b1;
                  wdata = '{id: hs, offset: e0[31:0], length: v[31:0]};
                  ec_next = ec + 1'b1;
                  el_next = el - 32'd1; fin = 1'b1;
                end
              end else begin
                el_next = el - 32'd1; fin = 1'b1;
              end
            end
            default: ph_next = PH_IDLE;
          endcase
        end
      end
      // Next entry or completion.
      if (fin && !bad) begin
        if (el_next == '0) begin st_next = StDone; ph_next = PH_IDLE; end
        else if (sum4 > {2'b0, pack_length}) bad = 1'b1;
        else ph_next = PH_NAMELEN;
      end
      if (bad) begin
        st_next = StBad; ph_next = PH_IDLE; ec_next = '0; we = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC; status <= StBusy; stored_count <= '0; byte_position <= '0;
      fcount <= '0; acc <= '0; hash <= FnvBasis; name_left <= '0;
      entries_left <= '0; f0 <= '0; f1 <= '0; f2 <= '0;
    end else if (take) begin
      phase <= ph_next; status <= st_next; stored_count <= ec_next;
      byte_position <= bp_next; fcount <= fc_next; acc <= ac_next; hash <= hs_next;
      name_left <= nl_next; entries_left <= el_next; f0 <= e0_next; f1 <= e1_next;
      f2 <= e2_next;
    end
  end

  // A table write always lands below the table size.
  assert property (@(posedge clk) disable iff (rst)
    we |-> stored_count < CountW'(TableEntries))
    else $error("table write past end");
  // A malformed pack leaves an empty table.
  assert property (@(posedge clk) disable iff (rst)
    status == StBad |-> stored_count == '0)
    else $error("malformed with entries");
  // Terminal status parks the parser.
  assert property (@(posedge clk) disable iff (rst)
    status != StBusy |-> phase == PH_IDLE || phase == PH_MAGIC)
    else $error("parser active after end");
endmodule

// ===== rtl/core/pack_index_parser_and_lookup_core.sv =====
// Top level: APB register, input/output channels, parser and table lookup walk.
// Depends on pilc_pkg, pilc_if, pilc_ram and pilc_parser.
//
// Channel  | Dir | Payload
// in_ch    | in  | op, first_byte, pack_byte, lookup_id
// out_ch   | out | parse_status, entries_stored, found, asset_offset, asset_length
// apb      | in  | pack_length at address 0
//
// A pack byte's result is registered at the accepting edge.
// While a result waits in the output register, no new transaction is taken, so the input
// takes no new transaction until the last result has left the output register.
// A lookup walks the table entries in index order through the registered read port: its
// result is registered when an entry's id matches the key or the index reaches
// entries_stored, and the input reopens after that result leaves.
// rst is synchronous; the table memory is not cleared, only the stored count.
module pack_index_parser_and_lookup_core
  import pilc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pilc_in_if.sink     in_ch,
  pilc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] pack_length;
  lk_state_t   lk, lk_next;
  logic        take, pwe;
  logic [TableAw:0] idx;
  logic [63:0] key;
  logic [1:0]  status;
  logic [CountW-1:0] stored_count;
  logic        we;
  logic [TableAw-1:0] waddr, raddr;
  entry_t      wdata, rdata;
  logic        rd_valid;

  // Configuration register.
  assign pready = 1'b1;
  assign pwe = psel && penable && pwrite;
  assign prdata = (paddr == RegPackLength) ? pack_length : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) pack_length <= '0;
    else if (pwe && paddr == RegPackLength) pack_length <= pwdata;
  end

  assign in_ch.ready = (lk == LK_IDLE) && !out_ch.valid;
  assign take = in_ch.valid && in_ch.ready && !in_ch.op;

  pilc_parser u_parser (
    .clk, .rst, .take, .first_byte(in_ch.first_byte), .pack_byte(in_ch.pack_byte),
    .pack_length, .status, .stored_count, .we, .waddr, .wdata
  );

  assign raddr = idx[TableAw-1:0];
  pilc_ram #(.Width($bits(entry_t)), .Depth(TableEntries)) u_table (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // Lookup walk state machine.
  always_comb begin
    lk_next = lk;
    unique case (lk)
      LK_IDLE: if (in_ch.valid && in_ch.ready && in_ch.op) lk_next = LK_READ;
      LK_READ: if (rd_valid && rdata.id == key) lk_next = LK_DONE;
               else if ({1'b0, idx} >= {{(TableAw - CountW + 2){1'b0}}, stored_count})
                 lk_next = LK_DONE;
      LK_DONE: lk_next = LK_IDLE;
      default: lk_next = LK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lk <= LK_IDLE; out_ch.valid <= 1'b0; idx <= '0; rd_valid <= 1'b0;
    end else begin
      lk <= lk_next;
      if (take || (lk == LK_READ && lk_next == LK_DONE)) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (lk == LK_IDLE && lk_next == LK_READ) begin
        idx <= '0; rd_valid <= 1'b0;
      end else if (lk == LK_READ) begin
        rd_valid <= {1'b0, idx} < {{(TableAw - CountW + 2){1'b0}}, stored_count};
        idx <= idx + 1'b1;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.op) key <= in_ch.lookup_id;
    if (take) begin
      out_ch.found <= 1'b0; out_ch.asset_offset <= '0; out_ch.asset_length <= '0;
    end else if (lk == LK_READ && lk_next == LK_DONE) begin
      out_ch.found <= rd_valid && rdata.id == key;
      out_ch.asset_offset <= (rd_valid && rdata.id == key) ? rdata.offset : '0;
      out_ch.asset_length <= (rd_valid && rdata.id == key) ? rdata.length : '0;
    end
  end
  assign out_ch.parse_status = status;
  assign out_ch.entries_stored = stored_count;

  // No input taken while a lookup walks.
  assert property (@(posedge clk) disable iff (rst) lk != LK_IDLE |-> !in_ch.ready)
    else $error("input taken during lookup");
  // Parser state holds during a lookup.
  assert property (@(posedge clk) disable iff (rst)
    lk == LK_READ |=> $stable(stored_count))
    else $error("table changed during lookup");
  // A found result always comes with a stored entry.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.found |-> stored_count != '0)
    else $error("found in empty table");
endmodule
